[hw/rtl/bps_pkg.sv]
// Package for the byte pattern scanner: transaction payload types,
// configuration register indexes and the configuration register set.
// No dependencies.
package bps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;
    localparam int OUT_ADDR_W  = 48;
    localparam int PAT_BYTES   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_LAST    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_BASE    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } in_item_t;

    typedef struct packed {
        logic                  found;
        logic [OUT_ADDR_W-1:0] match_address;
    } out_item_t;

    typedef struct packed {
        logic [63:0]           pattern_low;
        logic [63:0]           pattern_high;
        logic [LEN_W-1:0]      pattern_length;
        logic                  search_last;
        logic [OUT_ADDR_W-1:0] region_base;
    } cfg_t;

endpackage

[hw/rtl/bps_front.sv]
// Front end of the byte pattern scanner: takes bytes, keeps the window and
// the byte offset, and classifies each byte as match end or not.
// Depends on bps_pkg.
module bps_front #(
    parameter int PATTERN_MAX  = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  bps_pkg::in_item_t       item,
    input  bps_pkg::cfg_t           cfg,
    output logic                    hit,
    output logic                    last,
    output logic [ADDRESS_BITS-1:0] start
);
    import bps_pkg::*;

    localparam int PIDX_W = 4;

    logic [7:0]              win_reg  [PATTERN_MAX];
    logic [7:0]              win_next [PATTERN_MAX];
    logic [ADDRESS_BITS-1:0] offset_reg;
    logic [ADDRESS_BITS-1:0] offset_next;
    logic [8*PAT_BYTES-1:0]  pat_all;
    logic [7:0]              pat_bytes [PAT_BYTES];
    logic [LEN_W-1:0]        len_eff;
    logic [PATTERN_MAX-1:0]  lane_ok;
    logic                    offset_ok;

    assign pat_all = {cfg.pattern_high, cfg.pattern_low};

    always_comb
    begin
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pat_bytes[i] = pat_all[8*i +: 8];
        end
    end

    assign len_eff = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : cfg.pattern_length;

    // Window as it stands after the incoming byte is shifted in.
    always_comb
    begin
        win_next[0] = item.data_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    // Window entry k holds the byte that pattern byte len-1-k must equal.
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (LEN_W'(k) < len_eff)
            begin
                lane_ok[k] = (win_next[k] ==
                              pat_bytes[PIDX_W'(len_eff - LEN_W'(1) - LEN_W'(k))]);
            end
            else
            begin
                lane_ok[k] = 1'b1;
            end
        end
    end

    assign offset_ok = (len_eff != '0) &&
                       (offset_reg >= ADDRESS_BITS'(len_eff - LEN_W'(1)));
    assign hit   = offset_ok && (&lane_ok);
    assign last  = item.region_end;
    assign start = offset_reg + ADDRESS_BITS'(1) - ADDRESS_BITS'(len_eff);

    assign offset_next = (offset_reg != '1) ? offset_reg + ADDRESS_BITS'(1) : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            if (item.region_end)
            begin
                offset_reg <= '0;
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    win_reg[k] <= '0;
                end
            end
            else
            begin
                offset_reg <= offset_next;
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

endmodule

[hw/rtl/bps_queue.sv]
// Short register queue that decouples the scanner's front and back ends.
// Depends on nothing but its parameters.
module bps_queue #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/bps_back.sv]
// Back end of the byte pattern scanner: keeps the chosen match and drives
// the result register at the end of each region.
// Depends on bps_pkg.
module bps_back #(
    parameter int ADDRESS_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  logic                    q_hit,
    input  logic                    q_last,
    input  logic [ADDRESS_BITS-1:0] q_start,
    output logic                    q_pop,
    input  bps_pkg::cfg_t           cfg,
    output logic                    out_valid,
    input  logic                    out_stall,
    output bps_pkg::out_item_t      out_item
);
    import bps_pkg::*;

    logic                    have_match_reg;
    logic [ADDRESS_BITS-1:0] kept_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;
    logic                    hit_take;
    logic                    have_sel;
    logic [ADDRESS_BITS-1:0] kept_sel;
    logic [ADDRESS_BITS-1:0] addr_sum;

    // Only the region's final transaction needs the result register free.
    assign q_pop = q_valid && (!q_last || !out_valid_reg || !out_stall);

    assign hit_take = q_hit && (cfg.search_last || !have_match_reg);
    assign have_sel = have_match_reg || hit_take;
    assign kept_sel = hit_take ? q_start : kept_reg;
    assign addr_sum = ADDRESS_BITS'(cfg.region_base) + kept_sel;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_match_reg <= 1'b0;
            kept_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_last)
                begin
                    have_match_reg <= 1'b0;
                    kept_reg       <= '0;
                end
                else
                begin
                    have_match_reg <= have_sel;
                    kept_reg       <= kept_sel;
                end
            end
            if (q_pop && q_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_last)
        begin
            out_reg.found         <= have_sel;
            out_reg.match_address <= have_sel ? OUT_ADDR_W'(addr_sum) : '0;
        end
    end

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.found |-> out_reg.match_address == '0)
        else $error("result without a match carries a nonzero address");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_last |=> !have_match_reg && kept_reg == '0)
        else $error("match state not cleared at region end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_last |-> !(out_valid_reg && out_stall))
        else $error("pending result overwritten");

endmodule

[hw/rtl/byte_pattern_scanner_top.sv]
// Top level of the byte pattern scanner: configuration registers and the
// front end, queue and back end. Depends on bps_pkg, bps_front, bps_queue
// and bps_back.
//
// The scanner takes one byte of a region per clock cycle while the queue is
// not full and compares a window of the most recent bytes with a pattern of
// up to 16 bytes in parallel, so a byte may follow in every cycle while the
// queue is not full. Each accepted byte enters a two-entry queue in the cycle
// it is accepted; the back end takes one entry per cycle, unless a pending
// result holds the region's final entry, and, on the region's final byte,
// loads the result register, which is visible in the cycle after that entry
// leaves the queue. A stall on the result side holds only the final byte's
// entry; the front keeps accepting until the queue fills. Configuration writes
// are always ready and must be made while no region is in flight.
module byte_pattern_scanner_top #(
    parameter int PATTERN_MAX  = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bps_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bps_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bps_pkg::*;

    localparam int ENTRY_W = ADDRESS_BITS + 2;

    cfg_t                    cfg_reg;
    logic                    accept;
    logic                    f_hit;
    logic                    f_last;
    logic [ADDRESS_BITS-1:0] f_start;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic [ENTRY_W-1:0]      q_head;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.search_last    <= 1'b0;
            cfg_reg.region_base    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    cfg_reg.pattern_low    <= cfg_data;
                REG_PATTERN_HIGH:   cfg_reg.pattern_high   <= cfg_data;
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[LEN_W-1:0];
                REG_SEARCH_LAST:    cfg_reg.search_last    <= cfg_data[0];
                REG_REGION_BASE:    cfg_reg.region_base    <= cfg_data[OUT_ADDR_W-1:0];
                default:            ;
            endcase
        end
    end

    bps_front #(
        .PATTERN_MAX  (PATTERN_MAX),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .cfg    (cfg_reg),
        .hit    (f_hit),
        .last   (f_last),
        .start  (f_start)
    );

    bps_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata ({f_hit, f_last, f_start}),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .head  (q_head)
    );

    bps_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_hit     (q_head[ENTRY_W-1]),
        .q_last    (q_head[ENTRY_W-2]),
        .q_start   (q_head[ADDRESS_BITS-1:0]),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

[test/scan_checker.sv]
`timescale 1ns / 100ps
// Checker for the byte pattern scanner: watches the byte, result and register
// write channels, predicts each region's result and compares it field by field.
// Depends on bps_pkg.
module scan_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  bps_pkg::in_item_t               in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  bps_pkg::out_item_t              out_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              failures,
    output int                              pending
);

    import bps_pkg::*;

    cfg_t                  regs;
    logic [7:0]            window [PAT_BYTES];
    logic [OUT_ADDR_W-1:0] scanned;
    logic [OUT_ADDR_W-1:0] match_start;
    logic                  matched;
    out_item_t             region_results [$];

    function automatic logic [7:0] pattern_byte(input int j);
        logic [127:0] bytes;
        bytes = {regs.pattern_high, regs.pattern_low};
        return bytes[8*j +: 8];
    endfunction

    task automatic clear_scan;
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            window[i] = 8'h00;
        end
        scanned     = '0;
        match_start = '0;
        matched     = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_LOW:    regs.pattern_low    = data;
            REG_PATTERN_HIGH:   regs.pattern_high   = data;
            REG_PATTERN_LENGTH: regs.pattern_length = data[LEN_W-1:0];
            REG_SEARCH_LAST:    regs.search_last    = data[0];
            REG_REGION_BASE:    regs.region_base    = data[OUT_ADDR_W-1:0];
            default:            ;
        endcase
    endtask

    // Advances the scan by one byte and queues a result on the region's end.
    task automatic take_byte(input in_item_t item);
        int        len;
        bit        hit;
        out_item_t res;
        len = (regs.pattern_length > PAT_BYTES) ? PAT_BYTES : int'(regs.pattern_length);
        for (int i = PAT_BYTES - 1; i > 0; i--)
        begin
            window[i] = window[i-1];
        end
        window[0] = item.data_byte;
        // A match must start inside the current region, so enough bytes of it
        // have to be in the window.
        if (len > 0 && scanned >= OUT_ADDR_W'(len - 1))
        begin
            hit = 1'b1;
            for (int j = 0; j < len; j++)
            begin
                if (pattern_byte(j) != window[len-1-j])
                    hit = 1'b0;
            end
            if (hit && (regs.search_last || !matched))
            begin
                match_start = scanned - OUT_ADDR_W'(len - 1);
                matched     = 1'b1;
            end
        end
        if (scanned != '1)
            scanned = scanned + 1'b1;
        if (item.region_end)
        begin
            res.found         = matched;
            res.match_address = matched ? regs.region_base + match_start : '0;
            region_results.push_back(res);
            clear_scan();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int        bad;
        out_item_t want;
        if (!rst_n)
        begin
            regs                = '0;
            regs.pattern_length = LEN_W'(1);
            clear_scan();
            region_results.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && !out_stall)
            begin
                if (region_results.size() == 0)
                begin
                    $error("result transaction with no region pending: found %0b, match_address %h",
                           out_item.found, out_item.match_address);
                    bad++;
                end
                else
                begin
                    want = region_results.pop_front();
                    if (out_item.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, out_item.found);
                        bad++;
                    end
                    if (out_item.match_address !== want.match_address)
                    begin
                        $error("match_address: expected %h, actual %h",
                               want.match_address, out_item.match_address);
                        bad++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                take_byte(in_item);
            failures <= failures + bad;
            pending  <= region_results.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the byte pattern scanner: clock, reset, register writes,
// byte regions and result back-pressure, plus the final verdict.
// Depends on bps_pkg, byte_pattern_scanner_top and scan_checker.
module tb;

    import bps_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int TARGET_BYTES = 950;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     failures;
    int                     pending;
    int                     quiet;
    bit                     idle_on;
    logic [7:0]             pattern [PAT_BYTES];
    logic [7:0]             region [$];

    byte_pattern_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scan_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // Ends a run in which no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Result side: a random stall before each result transaction.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            n = idle_on ? $urandom_range(0, 3) : 0;
            @(negedge clk);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_end);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: b, region_end: is_end};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_region;
        for (int k = 0; k < region.size(); k++)
        begin
            send_byte(region[k], k == region.size() - 1);
        end
    endtask

    // Drains the scanner before any register is touched.
    task automatic settle;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [63:0] len_word, input logic [63:0] mode_word,
                             input logic [63:0] base_word, input bit junk);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int j = 0; j < 8; j++)
        begin
            lo[8*j +: 8] = pattern[j];
            hi[8*j +: 8] = pattern[j+8];
        end
        settle();
        cfg_write(REG_PATTERN_LOW, lo);
        cfg_write(REG_PATTERN_HIGH, hi);
        // Writes to unused indexes must leave every register alone.
        if (junk)
            cfg_write(REG_REGION_BASE + CFG_INDEX_W'($urandom_range(1, 3)),
                      {$urandom, $urandom});
        cfg_write(REG_PATTERN_LENGTH, len_word);
        cfg_write(REG_SEARCH_LAST, mode_word);
        cfg_write(REG_REGION_BASE, base_word);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0]  alpha [2];
        logic [63:0] len_word;
        logic [63:0] mode_word;
        logic [63:0] base_word;
        int          plen;
        int          eff;
        int          rlen;
        int          cut;
        int          sent;
        bit          noise;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_on   = 1'b1;
        sent      = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-byte pattern 00 in first mode at base 0.
        region = '{8'hFF, 8'h00};
        send_region();

        // Overlapping matches in last mode, address wrapping past the top, then a
        // region too short for the pattern right after one full of it.
        for (int j = 0; j < PAT_BYTES; j++)
        begin
            pattern[j] = (j < 8) ? 8'hFF : 8'h00;
        end
        configure(64'd2, 64'd1, 64'h0000_FFFF_FFFF_FFFF, 1'b0);
        region = '{8'hFF, 8'hFF, 8'hFF};
        send_region();
        region = '{8'hFF};
        send_region();

        // Zero length never matches.
        for (int j = 0; j < PAT_BYTES; j++)
        begin
            pattern[j] = 8'hFF;
        end
        configure(64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 1'b1);
        region = '{8'h00, 8'hFF};
        send_region();

        // Length above the maximum saturates; unused register bits are ignored.
        for (int j = 0; j < PAT_BYTES; j++)
        begin
            pattern[j] = 8'($urandom);
        end
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                  64'h1234_8000_0000_0001, 1'b1);
        region.delete();
        for (int j = 0; j < PAT_BYTES; j++)
        begin
            region.push_back(pattern[j]);
        end
        send_region();

        while (sent < TARGET_BYTES)
        begin
            alpha[0] = 8'($urandom);
            alpha[1] = 8'($urandom);
            case ($urandom_range(0, 9))
                0:       plen = 0;
                1:       plen = PAT_BYTES;
                2:       plen = $urandom_range(PAT_BYTES + 1, 31);
                default: plen = $urandom_range(1, 4);
            endcase
            eff = (plen > PAT_BYTES) ? PAT_BYTES : plen;
            for (int j = 0; j < PAT_BYTES; j++)
            begin
                pattern[j] = ($urandom_range(0, 3) != 0) ? alpha[$urandom_range(0, 1)]
                                                         : 8'($urandom);
            end
            len_word       = {$urandom, $urandom};
            len_word[4:0]  = 5'(plen);
            mode_word      = {$urandom, $urandom};
            base_word      = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0)
                base_word[47:0] = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 20));
            configure(len_word, mode_word, base_word, $urandom_range(0, 3) == 0);
            idle_on = ($urandom_range(0, 3) != 0);

            repeat ($urandom_range(3, 8))
            begin
                if (eff >= 12)
                    rlen = $urandom_range(12, 24);
                else if ($urandom_range(0, 9) == 0)
                    rlen = $urandom_range(17, 40);
                else
                    rlen = $urandom_range(1, 16);
                noise = ($urandom_range(0, 4) == 0);
                region.delete();
                // Mostly copies of the pattern in filler from the same alphabet;
                // cut copies and stray bytes break sequences up.
                while (region.size() < rlen)
                begin
                    case (noise ? 5 : $urandom_range(0, 5))
                        0, 1:
                        begin
                            for (int j = 0; j < eff; j++)
                                region.push_back(pattern[j]);
                        end
                        2:
                        begin
                            cut = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
                            for (int j = 0; j < cut; j++)
                                region.push_back(pattern[j]);
                        end
                        3, 4:    region.push_back(alpha[$urandom_range(0, 1)]);
                        default: region.push_back(8'($urandom));
                    endcase
                end
                while (region.size() > rlen)
                    void'(region.pop_back());
                send_region();
                sent += rlen;
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
